// File: rtl/fci_pkg.sv
// Shared constants and types for the flash command interface.
// Used by the top level, the array memory and the port checker.
package fci_pkg;

    localparam int ADDR_W      = 15;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 4;
    localparam int PADDR_W     = 3;
    localparam int ARRAY_WORDS = 2 ** ADDR_W;

    localparam int CHIP_WORDS_DEF  = 4096;
    localparam int CHIP_SLOTS_DEF  = 8;
    localparam int ERASE_WORDS_DEF = 256;

    localparam logic [COUNT_W-1:0] CHIP_COUNT_RESET = COUNT_W'(2);

    // Register index decoded from paddr[2].
    localparam logic REG_CHIP_COUNT = 1'b0;

    localparam logic [DATA_W-1:0] CMD_IDENT    = 32'h9090_0000;
    localparam logic [DATA_W-1:0] CMD_STATUS_A = 32'h0070_0000;
    localparam logic [DATA_W-1:0] CMD_STATUS_B = 32'h7070_0000;
    localparam logic [DATA_W-1:0] CMD_STATUS_C = 32'he8e8_0000;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 32'h2020_0000;
    localparam logic [DATA_W-1:0] CMD_CONFIRM  = 32'hd0d0_0000;
    localparam logic [DATA_W-1:0] CMD_PROGRAM  = 32'h0f0f_0000;
    localparam logic [DATA_W-1:0] ANS_IDENT    = 32'h0089_0014;
    localparam logic [DATA_W-1:0] ANS_READY    = 32'h0080_0000;
    localparam logic [DATA_W-1:0] ANS_READY2   = 32'h0082_0000;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: rtl/fci_mem.sv
// Flash array storage: one write port and one read port with registered read data.
// Depends on fci_pkg for widths and the request struct.
module fci_mem (
    input  logic                      i_clk,
    input  fci_pkg::t_mem_req         i_req,
    output logic [fci_pkg::DATA_W-1:0] o_rdata
);

    logic [fci_pkg::DATA_W-1:0] r_mem [fci_pkg::ARRAY_WORDS];
    logic [fci_pkg::DATA_W-1:0] r_rdata;

    // Read data holds its value while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/flash_command_interface_top.sv
// A 32-bit word flash array behind a command latch, with an APB register for the
// number of top chip slots that answer identifier and status commands. A read
// passes the array read register, then the result register. Latch loads, ignored
// writes and program confirms pass the result state, then the result register, and
// program data writes read, merge one 16-bit half and write back. An erase confirm
// at address A clears min(ERASE_WORDS, 32768 - A) words, one word per cycle through the
// array's single write port. One request is in work at a time; the result
// register lets the next request enter while a result still waits to be taken.
// The array is not cleared by reset.
// Depends on fci_pkg and fci_mem.
module flash_command_interface_top #(
    parameter int CHIP_WORDS  = fci_pkg::CHIP_WORDS_DEF,
    parameter int CHIP_SLOTS  = fci_pkg::CHIP_SLOTS_DEF,
    parameter int ERASE_WORDS = fci_pkg::ERASE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fci_pkg::PADDR_W-1:0] paddr,
    input  logic [fci_pkg::DATA_W-1:0]  pwdata,
    output logic [fci_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [fci_pkg::ADDR_W-1:0]  i_word_addr,
    input  logic [fci_pkg::DATA_W-1:0]  i_write_data,
    input  logic                        i_low_lane,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [fci_pkg::DATA_W-1:0]  o_read_data
);

    localparam int START_W = $clog2(CHIP_SLOTS * CHIP_WORDS + 1);
    localparam int CMP_W   = (START_W > fci_pkg::ADDR_W) ? START_W : fci_pkg::ADDR_W;
    localparam int ECNT_W  = $clog2(ERASE_WORDS);
    localparam int HALF_W  = fci_pkg::DATA_W / 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROG,
        S_ERASE,
        S_RESULT
    } t_state;

    t_state                        r_state, n_state;
    logic [fci_pkg::COUNT_W-1:0]   r_chip_count;
    logic [fci_pkg::DATA_W-1:0]    r_latch, n_latch;
    logic [fci_pkg::ADDR_W-1:0]    r_first, n_first;
    logic                          r_held, n_held;
    logic [fci_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [fci_pkg::DATA_W-1:0]    r_data, n_data;
    logic                          r_low, n_low;
    logic [fci_pkg::ADDR_W-1:0]    r_ptr, n_ptr;
    logic [ECNT_W-1:0]             r_ecnt, n_ecnt;
    logic                          r_out_valid, n_out_valid;
    logic [fci_pkg::DATA_W-1:0]    r_out_data, n_out_data;

    fci_pkg::t_mem_req             mem_req;
    logic [fci_pkg::DATA_W-1:0]    mem_rdata;

    logic                          cfg_wr;
    logic                          in_acc;
    logic                          out_free;
    logic [fci_pkg::COUNT_W-1:0]   cnt_clip;
    logic [START_W-1:0]            win_start;
    logic                          in_window;
    logic [fci_pkg::DATA_W-1:0]    read_value;
    logic [fci_pkg::DATA_W-1:0]    merged;
    logic                          erase_last;

    fci_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == fci_pkg::REG_CHIP_COUNT);
    assign prdata = (paddr[2] == fci_pkg::REG_CHIP_COUNT) ?
                    fci_pkg::DATA_W'(r_chip_count) : '0;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // Counts above the slot count cover the whole array.
    assign cnt_clip  = (int'(r_chip_count) > CHIP_SLOTS) ?
                       fci_pkg::COUNT_W'(CHIP_SLOTS) : r_chip_count;
    assign win_start = START_W'((CHIP_SLOTS - int'(cnt_clip)) * CHIP_WORDS);
    assign in_window = CMP_W'(r_addr) >= CMP_W'(win_start);

    always_comb begin
        read_value = mem_rdata;
        if (in_window) begin
            if (r_latch == fci_pkg::CMD_IDENT) begin
                read_value = fci_pkg::ANS_IDENT;
            end else if (r_latch == fci_pkg::CMD_STATUS_A ||
                         r_latch == fci_pkg::CMD_STATUS_C) begin
                read_value = fci_pkg::ANS_READY;
            end else if (r_latch == fci_pkg::CMD_STATUS_B) begin
                read_value = fci_pkg::ANS_READY2;
            end
        end
    end

    assign merged = r_low ? {mem_rdata[fci_pkg::DATA_W-1:HALF_W], r_data[HALF_W-1:0]}
                          : {r_data[fci_pkg::DATA_W-1:HALF_W], mem_rdata[HALF_W-1:0]};

    assign erase_last = (r_ecnt == ECNT_W'(ERASE_WORDS - 1)) || (&r_ptr);

    always_comb begin
        n_state     = r_state;
        n_latch     = r_latch;
        n_first     = r_first;
        n_held      = r_held;
        n_addr      = r_addr;
        n_data      = r_data;
        n_low       = r_low;
        n_ptr       = r_ptr;
        n_ecnt      = r_ecnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_req     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_addr = i_word_addr;
                    n_data = i_write_data;
                    n_low  = i_low_lane;
                    if (i_req_type == fci_pkg::REQ_READ) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = i_word_addr;
                        n_state       = S_READ;
                    end else if (r_latch == fci_pkg::CMD_ERASE) begin
                        if (i_write_data == fci_pkg::CMD_CONFIRM) begin
                            n_ptr   = i_word_addr;
                            n_ecnt  = '0;
                            n_state = S_ERASE;
                        end else begin
                            n_state = S_RESULT;
                        end
                    end else if (r_latch == fci_pkg::CMD_PROGRAM) begin
                        if (i_write_data == fci_pkg::CMD_CONFIRM && r_held &&
                            i_word_addr == r_first) begin
                            n_latch = '0;
                            n_held  = 1'b0;
                            n_first = '0;
                            n_state = S_RESULT;
                        end else begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = i_word_addr;
                            n_state       = S_PROG;
                        end
                    end else begin
                        n_latch = i_write_data;
                        if (i_write_data == fci_pkg::CMD_PROGRAM && !r_held) begin
                            n_first = i_word_addr;
                            n_held  = 1'b1;
                        end
                        n_state = S_RESULT;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = read_value;
                    n_state     = S_IDLE;
                end
            end
            S_PROG: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_addr;
                mem_req.wdata = merged;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_ERASE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ptr;
                mem_req.wdata = '1;
                if (erase_last) begin
                    n_latch = '0;
                    n_state = S_RESULT;
                end else begin
                    n_ptr  = r_ptr + 1'b1;
                    n_ecnt = r_ecnt + 1'b1;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chip_count <= fci_pkg::CHIP_COUNT_RESET;
            r_latch      <= '0;
            r_first      <= '0;
            r_held       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_latch     <= n_latch;
            r_first     <= n_first;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_chip_count <= pwdata[fci_pkg::COUNT_W-1:0];
            end
        end
        r_addr     <= n_addr;
        r_data     <= n_data;
        r_low      <= n_low;
        r_ptr      <= n_ptr;
        r_ecnt     <= n_ecnt;
        r_out_data <= n_out_data;
    end

endmodule

// File: rtl/fci_checker.sv
// Port-level checks for the flash command interface, bound to the top level.
// Depends on fci_pkg for widths.
module fci_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        pready,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [fci_pkg::DATA_W-1:0]  o_read_data
);

    // A result waiting under stall stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A result waiting under stall keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_read_data))
        else $error("result data changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in work");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind flash_command_interface_top fci_checker u_fci_checker (.*);

// File: verif/fci_access_checker.sv
// Port checker for the flash command interface: mirrors the chip count register,
// the command latch and the whole array, and compares every result with its request.
// Depends on fci_pkg; instantiated beside the block by the testbench top.
module fci_access_checker
    import fci_pkg::*;
#(
    parameter int CHIP_WORDS  = CHIP_WORDS_DEF,
    parameter int CHIP_SLOTS  = CHIP_SLOTS_DEF,
    parameter int ERASE_WORDS = ERASE_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_req_type,
    input  logic [ADDR_W-1:0]  i_word_addr,
    input  logic [DATA_W-1:0]  i_write_data,
    input  logic               i_low_lane,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [DATA_W-1:0]  i_read_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_access_result;

    t_access_result     results_due[$];
    logic [COUNT_W-1:0] chip_count;
    logic [DATA_W-1:0]  cmd_latch;
    logic [ADDR_W-1:0]  prog_first;
    logic               prog_held;
    logic [DATA_W-1:0]  flash_words [ARRAY_WORDS];
    int                 fails = 0;

    function automatic logic in_id_window(logic [ADDR_W-1:0] a);
        int cnt;
        cnt = (int'(chip_count) > CHIP_SLOTS) ? CHIP_SLOTS : int'(chip_count);
        return int'(a) >= (CHIP_SLOTS - cnt) * CHIP_WORDS;
    endfunction

    // Applies one request to the mirrored state and returns the word it reads back.
    function automatic logic [DATA_W-1:0] flash_access(logic kind, logic [ADDR_W-1:0] a,
                                                       logic [DATA_W-1:0] d, logic low);
        logic [DATA_W-1:0] word;
        int                stop;
        if (kind == REQ_READ) begin
            if (in_id_window(a)) begin
                if (cmd_latch == CMD_IDENT) return ANS_IDENT;
                if (cmd_latch == CMD_STATUS_A || cmd_latch == CMD_STATUS_C) return ANS_READY;
                if (cmd_latch == CMD_STATUS_B) return ANS_READY2;
            end
            return flash_words[a];
        end
        if (cmd_latch == CMD_ERASE) begin
            if (d == CMD_CONFIRM) begin
                stop = int'(a) + ERASE_WORDS;
                if (stop > ARRAY_WORDS) stop = ARRAY_WORDS;
                for (int k = int'(a); k < stop; k++) flash_words[k] = '1;
                cmd_latch = '0;
            end
        end else if (cmd_latch == CMD_PROGRAM) begin
            if (d == CMD_CONFIRM && prog_held && a == prog_first) begin
                cmd_latch  = '0;
                prog_held  = 1'b0;
                prog_first = '0;
            end else begin
                word = flash_words[a];
                if (low) word[15:0] = d[15:0];
                else word[31:16] = d[31:16];
                flash_words[a] = word;
            end
        end else begin
            cmd_latch = d;
            if (d == CMD_PROGRAM && !prog_held) begin
                prog_first = a;
                prog_held  = 1'b1;
            end
        end
        return '0;
    endfunction

    always @(posedge i_clk) begin
        t_access_result due;
        if (!i_rst_n) begin
            chip_count = CHIP_COUNT_RESET;
            cmd_latch  = '0;
            prog_first = '0;
            prog_held  = 1'b0;
            results_due.delete();
        end else begin
            // A result leaving at this edge belongs to an earlier request, so pop first.
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("checker: result %h with no request waiting",
                                              i_read_data);
                end else begin
                    due = results_due.pop_front();
                    if (i_read_data !== due.data) begin
                        fails++;
                        if (fails <= 10)
                            $display("checker: request at %h: expected %h, got %h",
                                     due.addr, due.data, i_read_data);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due.addr = i_word_addr;
                due.data = flash_access(i_req_type, i_word_addr, i_write_data, i_low_lane);
                results_due.push_back(due);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_CHIP_COUNT)
                chip_count = i_pwdata[COUNT_W-1:0];
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// File: verif/testbench.sv
// Testbench top for the flash command interface: clock, reset, chip count writes and
// request stimulus with random idling; the verdict comes from the port checker.
// Depends on fci_pkg, flash_command_interface_top and fci_access_checker.
module testbench;
    import fci_pkg::*;

    localparam int CHIP_WORDS     = CHIP_WORDS_DEF;
    localparam int CHIP_SLOTS     = CHIP_SLOTS_DEF;
    localparam int ERASE_WORDS    = ERASE_WORDS_DEF;
    localparam int IDLE_PCT       = 27;
    localparam int PHASE_ITEMS    = 15;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               req_type = REQ_READ;
    logic [ADDR_W-1:0]  word_addr = '0;
    logic [DATA_W-1:0]  write_data = '0;
    logic               low_lane = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DATA_W-1:0]  read_data;
    int                 fail_count;
    int                 pending;

    // Stimulus-side view of the latch, so sequences know how to leave a mode.
    logic [DATA_W-1:0]  cmd_now = '0;
    logic [ADDR_W-1:0]  prog_first = '0;
    logic               prog_open = 1'b0;
    logic [COUNT_W-1:0] cur_count = CHIP_COUNT_RESET;
    logic [ADDR_W-1:0]  hot_addr [8];
    logic               calm = 1'b0;
    int                 idle_cycles = 0;
    int                 n_items = 0;
    int                 n_erase = 0;
    int                 n_prog = 0;
    int                 n_settings = 0;

    flash_command_interface_top #(
        .CHIP_WORDS (CHIP_WORDS),
        .CHIP_SLOTS (CHIP_SLOTS),
        .ERASE_WORDS(ERASE_WORDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_word_addr (word_addr),
        .i_write_data(write_data),
        .i_low_lane  (low_lane),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_read_data (read_data)
    );

    fci_access_checker #(
        .CHIP_WORDS (CHIP_WORDS),
        .CHIP_SLOTS (CHIP_SLOTS),
        .ERASE_WORDS(ERASE_WORDS)
    ) access_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_word_addr (word_addr),
        .i_write_data(write_data),
        .i_low_lane  (low_lane),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_read_data (read_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int window_start();
        int cnt;
        cnt = (int'(cur_count) > CHIP_SLOTS) ? CHIP_SLOTS : int'(cur_count);
        return (CHIP_SLOTS - cnt) * CHIP_WORDS;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int w;
        case ($urandom_range(0, 3))
            0: return ADDR_W'($urandom_range(0, ARRAY_WORDS - 1));
            1: begin
                w = window_start() + int'($urandom_range(0, 8)) - 4;
                if (w < 0) w = 0;
                if (w > ARRAY_WORDS - 1) w = ARRAY_WORDS - 1;
                return ADDR_W'(w);
            end
            2: return hot_addr[3'($urandom_range(0, 7))];
            default: return ADDR_W'($urandom_range(ARRAY_WORDS - 80, ARRAY_WORDS - 1));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_command();
        case ($urandom_range(0, 7))
            0: return CMD_IDENT;
            1: return CMD_STATUS_A;
            2: return CMD_STATUS_B;
            3: return CMD_STATUS_C;
            4: return CMD_ERASE;
            5: return CMD_CONFIRM;
            6: return CMD_PROGRAM;
            default: return $urandom();
        endcase
    endfunction

    // Presents one request and returns at the edge where it is taken. Valid is
    // left high so a following request can go out without a gap.
    task automatic send_req(logic kind, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                            logic lane);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        word_addr  <= a;
        write_data <= d;
        low_lane   <= lane;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        n_items++;
        if (kind == REQ_WRITE) begin
            if (cmd_now == CMD_ERASE) begin
                if (d == CMD_CONFIRM) begin
                    cmd_now = '0;
                    n_erase++;
                end
            end else if (cmd_now == CMD_PROGRAM) begin
                if (d == CMD_CONFIRM && a == prog_first) begin
                    cmd_now   = '0;
                    prog_open = 1'b0;
                end else begin
                    n_prog++;
                end
            end else begin
                cmd_now = d;
                if (d == CMD_PROGRAM && !prog_open) begin
                    prog_first = a;
                    prog_open  = 1'b1;
                end
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_chip_count(logic [COUNT_W-1:0] v);
        drain_results();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_CHIP_COUNT, 2'b00});
        pwdata  <= ($urandom() & ~32'hF) | DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_count = v;
        n_settings++;
    endtask

    task automatic random_sequence();
        logic [ADDR_W-1:0] pa;
        int                n;
        // Most sequences start from a plain latch; the rest run inside a leftover mode.
        if ($urandom_range(0, 4) != 0) begin
            if (cmd_now == CMD_ERASE)
                send_req(REQ_WRITE, pick_addr(), CMD_CONFIRM, rand_bit());
            else if (cmd_now == CMD_PROGRAM)
                send_req(REQ_WRITE, prog_first, CMD_CONFIRM, rand_bit());
        end
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                repeat ($urandom_range(1, 4))
                    send_req(REQ_READ, pick_addr(), $urandom(), rand_bit());
            end
            3, 4: begin
                send_req(REQ_WRITE, pick_addr(), pick_command(), rand_bit());
                repeat ($urandom_range(1, 3))
                    send_req(REQ_READ, pick_addr(), $urandom(), rand_bit());
            end
            5, 6: begin
                pa = pick_addr();
                send_req(REQ_WRITE, pa, CMD_PROGRAM, rand_bit());
                n = $urandom_range(1, 4);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: send_req(REQ_READ, pick_addr(), $urandom(), rand_bit());
                        1: send_req(REQ_WRITE, pick_addr(),
                                    ($urandom_range(0, 3) == 0) ? CMD_CONFIRM : $urandom(),
                                    rand_bit());
                        default: send_req(REQ_WRITE, pa, $urandom(), rand_bit());
                    endcase
                end
                if (cmd_now == CMD_PROGRAM)
                    send_req(REQ_WRITE, prog_first, CMD_CONFIRM, rand_bit());
                send_req(REQ_READ, pa, $urandom(), rand_bit());
            end
            7: begin
                send_req(REQ_WRITE, pick_addr(), CMD_ERASE, rand_bit());
                if ($urandom_range(0, 1) == 1)
                    send_req(REQ_WRITE, pick_addr(), $urandom() | 32'h1, rand_bit());
                pa = pick_addr();
                send_req(REQ_WRITE, pa, CMD_CONFIRM, rand_bit());
                send_req(REQ_READ, pa, $urandom(), rand_bit());
                send_req(REQ_READ, pick_addr(), $urandom(), rand_bit());
            end
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    send_req(REQ_WRITE, pick_addr(),
                             ($urandom_range(0, 1) == 1) ? pick_command() : $urandom(),
                             rand_bit());
                    if ($urandom_range(0, 1) == 1)
                        send_req(REQ_READ, pick_addr(), $urandom(), rand_bit());
                end
            end
        endcase
    endtask

    initial begin
        logic [COUNT_W-1:0] settings [8];
        int                 target;
        settings = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd5, COUNT_W'($urandom_range(0, 15)), 4'd2, 4'd3};
        foreach (hot_addr[i]) hot_addr[i] = ADDR_W'($urandom());
        hot_addr[0] = '0;
        hot_addr[7] = '1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The power-up image is not known here, so erase the whole array first.
        // Neither side idles during this long stretch.
        calm = 1'b1;
        for (int b = 0; b < ARRAY_WORDS / ERASE_WORDS; b++) begin
            send_req(REQ_WRITE, ADDR_W'($urandom()), CMD_ERASE, rand_bit());
            send_req(REQ_WRITE, ADDR_W'(b * ERASE_WORDS), CMD_CONFIRM, rand_bit());
        end
        calm = 1'b0;

        // Identifier and status answers on both sides of the window start.
        send_req(REQ_WRITE, 15'd5, CMD_IDENT, 1'b1);
        send_req(REQ_READ, ADDR_W'(window_start()), '1, 1'b1);
        send_req(REQ_READ, ADDR_W'(window_start() - 1), '0, 1'b0);
        send_req(REQ_WRITE, 15'd0, CMD_STATUS_A, 1'b0);
        send_req(REQ_READ, '1, 32'h5555_aaaa, 1'b1);
        send_req(REQ_WRITE, 15'd7, CMD_STATUS_C, 1'b1);
        send_req(REQ_READ, 15'd30000, '0, 1'b0);
        send_req(REQ_WRITE, '1, CMD_STATUS_B, 1'b0);
        send_req(REQ_READ, ADDR_W'(window_start()), '0, 1'b0);
        send_req(REQ_READ, 15'd0, '0, 1'b1);
        // Program both halves, a confirm at the wrong address, then the real confirm.
        send_req(REQ_WRITE, 15'd100, CMD_PROGRAM, 1'b1);
        send_req(REQ_WRITE, 15'd100, 32'h1234_abcd, 1'b1);
        send_req(REQ_WRITE, 15'd100, 32'hdead_5555, 1'b0);
        send_req(REQ_WRITE, 15'd101, CMD_CONFIRM, 1'b0);
        send_req(REQ_WRITE, '1, 32'h0000_0000, 1'b1);
        send_req(REQ_WRITE, 15'd100, CMD_CONFIRM, 1'b1);
        send_req(REQ_READ, 15'd100, '0, 1'b0);
        send_req(REQ_READ, 15'd101, '0, 1'b0);
        // Erase with an ignored write in between, clipped at the top of the array.
        send_req(REQ_WRITE, 15'd0, CMD_ERASE, 1'b0);
        send_req(REQ_WRITE, 15'd3, 32'h1234_5678, 1'b1);
        send_req(REQ_WRITE, 15'd32700, CMD_CONFIRM, 1'b0);
        send_req(REQ_READ, '1, '0, 1'b0);
        send_req(REQ_WRITE, 15'd0, '1, 1'b1);
        send_req(REQ_WRITE, '1, '0, 1'b0);
        send_req(REQ_READ, ADDR_W'(window_start()), '0, 1'b1);

        for (int p = 0; p < 8; p++) begin
            set_chip_count(settings[p]);
            calm   = (p == 3);
            target = n_items + PHASE_ITEMS;
            while (n_items < target) begin
                random_sequence();
                if (p == 5 && n_items >= target - PHASE_ITEMS / 2 && n_settings == 6) begin
                    // Hold off once mid-phase until the block has answered everything.
                    drain_results();
                    n_settings++;
                end
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d requests, %0d erase confirms, %0d program data writes,",
                 n_items, n_erase, n_prog);
        $display("summary: chip count swept through 0, 1, 2, 3, 5, 8, 15 and a random value");
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
